/* rtl/core/scuf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scuf_pkg
// Shared widths, defaults and codes for the source constrained union-find.
// ----------------------------------------------------------------------------
package scuf_pkg;

    localparam int MaxMembersDefault = 1024;
    localparam int NumSourcesDefault = 16;

    // Port field widths
    localparam int MemberW    = 10;
    localparam int SourceIdxW = 4;
    localparam int CmdW       = 2;

    typedef enum logic [CmdW-1:0] {
        CMD_LOAD = 2'd0,
        CMD_JOIN = 2'd1,
        CMD_FIND = 2'd2
    } cmd_t;

    // Write strobes from the sequencer to the two tables
    typedef struct packed {
        logic parent_we;
        logic sources_we;
    } mem_wr_t;

endpackage

/* rtl/core/scuf_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scuf_mem
// Single-port-write, single-port-read synchronous table with a registered
// read, write data forwarded to a read of the same entry.
// ----------------------------------------------------------------------------
module scuf_mem #(
    parameter int DEPTH = scuf_pkg::MaxMembersDefault,
    parameter int WIDTH = scuf_pkg::MemberW
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/scuf_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scuf_reduce
// Two-stage reduction of the raw member fields modulo the table depth
// (reciprocal multiply, then subtract), and a registered reduction of the
// source field modulo the source count.
// ----------------------------------------------------------------------------
module scuf_reduce #(
    parameter int MAX_MEMBERS = scuf_pkg::MaxMembersDefault,
    parameter int NUM_SOURCES = scuf_pkg::NumSourcesDefault
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic [scuf_pkg::MemberW-1:0]         first_raw,
    input  logic [scuf_pkg::MemberW-1:0]         second_raw,
    input  logic [scuf_pkg::SourceIdxW-1:0]      source_raw,
    output logic [$clog2(MAX_MEMBERS)-1:0]       first_idx,
    output logic [$clog2(MAX_MEMBERS)-1:0]       second_idx,
    output logic [$clog2(NUM_SOURCES)-1:0]       source_idx
);

    localparam int MW = $clog2(MAX_MEMBERS);
    localparam int SW = $clog2(NUM_SOURCES);

    logic [scuf_pkg::MemberW-1:0]    a_raw_reg;
    logic [scuf_pkg::MemberW-1:0]    b_raw_reg;
    logic [scuf_pkg::SourceIdxW-1:0] s_raw_reg;
    logic [MW-1:0]                   a_reg;
    logic [MW-1:0]                   b_reg;
    logic [SW-1:0]                   s_red;
    logic [SW-1:0]                   s_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_raw_reg <= first_raw;
            b_raw_reg <= second_raw;
            s_raw_reg <= source_raw;
        end
    end

    generate
        if (MAX_MEMBERS >= (1 << scuf_pkg::MemberW))
        begin : g_member_wide
            logic [MW-1:0] a_mid_reg;
            logic [MW-1:0] b_mid_reg;

            always_ff @(posedge clk)
            begin
                a_mid_reg <= MW'(a_raw_reg);
                b_mid_reg <= MW'(b_raw_reg);
                a_reg     <= a_mid_reg;
                b_reg     <= b_mid_reg;
            end
        end
        else
        begin : g_member_mod
            localparam int Shift  = scuf_pkg::MemberW + MW;
            localparam int Recip  = ((1 << Shift) + MAX_MEMBERS - 1) / MAX_MEMBERS;
            localparam int RecipW = scuf_pkg::MemberW + 2;
            localparam int ProdW  = scuf_pkg::MemberW + RecipW;

            logic [ProdW-1:0]             a_prod;
            logic [ProdW-1:0]             b_prod;
            logic [scuf_pkg::MemberW-1:0] a_q_reg;
            logic [scuf_pkg::MemberW-1:0] b_q_reg;
            logic [scuf_pkg::MemberW-1:0] a_rem;
            logic [scuf_pkg::MemberW-1:0] b_rem;

            // quotient by reciprocal, exact for all 10-bit inputs
            assign a_prod = ProdW'(a_raw_reg) * ProdW'(Recip);
            assign b_prod = ProdW'(b_raw_reg) * ProdW'(Recip);

            assign a_rem = a_raw_reg - scuf_pkg::MemberW'(a_q_reg *
                           scuf_pkg::MemberW'(MAX_MEMBERS));
            assign b_rem = b_raw_reg - scuf_pkg::MemberW'(b_q_reg *
                           scuf_pkg::MemberW'(MAX_MEMBERS));

            always_ff @(posedge clk)
            begin
                a_q_reg <= scuf_pkg::MemberW'(a_prod >> Shift);
                b_q_reg <= scuf_pkg::MemberW'(b_prod >> Shift);
                a_reg   <= MW'(a_rem);
                b_reg   <= MW'(b_rem);
            end
        end

        if (NUM_SOURCES >= (1 << scuf_pkg::SourceIdxW))
        begin : g_source_wide
            assign s_red = SW'(s_raw_reg);
        end
        else
        begin : g_source_mod
            logic [scuf_pkg::SourceIdxW-1:0] s_work;

            // at most seven subtractions on a 4-bit value
            always_comb
            begin
                s_work = s_raw_reg;
                for (int i = 0; i < 8; i++)
                begin
                    if (s_work >= scuf_pkg::SourceIdxW'(NUM_SOURCES))
                    begin
                        s_work = s_work - scuf_pkg::SourceIdxW'(NUM_SOURCES);
                    end
                end
            end

            assign s_red = SW'(s_work);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        s_reg <= s_red;
    end

    assign first_idx  = a_reg;
    assign second_idx = b_reg;
    assign source_idx = s_reg;

endmodule

/* rtl/core/scuf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scuf_ctrl
// Command sequencer: load, path-halving walk over the parent table, and the
// source-checked join, with a one-entry output register.
// ----------------------------------------------------------------------------
module scuf_ctrl #(
    parameter int MAX_MEMBERS = scuf_pkg::MaxMembersDefault,
    parameter int NUM_SOURCES = scuf_pkg::NumSourcesDefault
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [scuf_pkg::CmdW-1:0]          cmd,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [scuf_pkg::MemberW-1:0]       root,
    output logic                               accepted,
    output logic                               load,
    input  logic [$clog2(MAX_MEMBERS)-1:0]     first_idx,
    input  logic [$clog2(MAX_MEMBERS)-1:0]     second_idx,
    input  logic [$clog2(NUM_SOURCES)-1:0]     source_idx,
    output scuf_pkg::mem_wr_t                  wr,
    output logic [$clog2(MAX_MEMBERS)-1:0]     p_waddr,
    output logic [$clog2(MAX_MEMBERS)-1:0]     p_wdata,
    output logic [$clog2(MAX_MEMBERS)-1:0]     p_raddr,
    input  logic [$clog2(MAX_MEMBERS)-1:0]     p_rdata,
    output logic [$clog2(MAX_MEMBERS)-1:0]     s_waddr,
    output logic [NUM_SOURCES-1:0]             s_wdata,
    output logic [$clog2(MAX_MEMBERS)-1:0]     s_raddr,
    input  logic [NUM_SOURCES-1:0]             s_rdata
);

    localparam int MW = $clog2(MAX_MEMBERS);
    localparam int CW = $clog2(MAX_MEMBERS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED1,
        ST_RED2,
        ST_DISPATCH,
        ST_WALK_P,
        ST_WALK_GP,
        ST_SRC_A,
        ST_SRC_B,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    state_t                       state_reg,      state_next;
    scuf_pkg::cmd_t               cmd_reg,        cmd_next;
    logic [MW-1:0]                x_reg,          x_next;
    logic [CW-1:0]                steps_reg,      steps_next;
    logic                         second_reg,     second_next;
    logic [MW-1:0]                ra_reg,         ra_next;
    logic [MW-1:0]                hi_reg,         hi_next;
    logic [NUM_SOURCES-1:0]       sa_reg,         sa_next;
    logic [MW-1:0]                res_root_reg,   res_root_next;
    logic                         res_ok_reg,     res_ok_next;
    logic                         out_valid_reg,  out_valid_next;
    logic [scuf_pkg::MemberW-1:0] root_reg,       root_next;
    logic                         accepted_reg,   accepted_next;

    logic [MW-1:0] lo_idx;
    logic [MW-1:0] hi_idx;

    // x_reg holds the second root once the second walk ends
    assign lo_idx = (ra_reg < x_reg) ? ra_reg : x_reg;
    assign hi_idx = (ra_reg < x_reg) ? x_reg : ra_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign accepted  = accepted_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        steps_next     = steps_reg;
        second_next    = second_reg;
        ra_next        = ra_reg;
        hi_next        = hi_reg;
        sa_next        = sa_reg;
        res_root_next  = res_root_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        root_next      = root_reg;
        accepted_next  = accepted_reg;

        load    = 1'b0;
        wr      = '0;
        p_waddr = x_reg;
        p_wdata = p_rdata;
        p_raddr = x_reg;
        s_waddr = lo_idx;
        s_wdata = '0;
        s_raddr = ra_reg;

        // drop the output transaction once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    load       = 1'b1;
                    cmd_next   = scuf_pkg::cmd_t'(cmd);
                    state_next = ST_RED1;
                end
            end

            ST_RED1:
            begin
                state_next = ST_RED2;
            end

            ST_RED2:
            begin
                state_next = ST_DISPATCH;
            end

            ST_DISPATCH:
            begin
                case (cmd_reg)
                    scuf_pkg::CMD_LOAD:
                    begin
                        wr.parent_we  = 1'b1;
                        wr.sources_we = 1'b1;
                        p_waddr       = first_idx;
                        p_wdata       = first_idx;
                        s_waddr       = first_idx;
                        s_wdata       = NUM_SOURCES'(1) << source_idx;
                        res_root_next = first_idx;
                        res_ok_next   = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    scuf_pkg::CMD_JOIN, scuf_pkg::CMD_FIND:
                    begin
                        x_next      = first_idx;
                        steps_next  = '0;
                        second_next = 1'b0;
                        p_raddr     = first_idx;
                        state_next  = ST_WALK_P;
                    end
                    default:
                    begin
                        res_root_next = '0;
                        res_ok_next   = 1'b0;
                        state_next    = ST_FINISH;
                    end
                endcase
            end

            ST_WALK_P:
            begin
                if ((p_rdata == x_reg) || (steps_reg == CW'(MAX_MEMBERS)))
                begin
                    if ((cmd_reg == scuf_pkg::CMD_JOIN) && !second_reg)
                    begin
                        // first root found, start the second walk
                        ra_next     = x_reg;
                        second_next = 1'b1;
                        x_next      = second_idx;
                        steps_next  = '0;
                        p_raddr     = second_idx;
                    end
                    else if (cmd_reg == scuf_pkg::CMD_JOIN)
                    begin
                        if (x_reg == ra_reg)
                        begin
                            res_root_next = ra_reg;
                            res_ok_next   = 1'b1;
                            state_next    = ST_FINISH;
                        end
                        else
                        begin
                            s_raddr    = ra_reg;
                            state_next = ST_SRC_A;
                        end
                    end
                    else
                    begin
                        res_root_next = x_reg;
                        res_ok_next   = 1'b1;
                        state_next    = ST_FINISH;
                    end
                end
                else
                begin
                    p_raddr    = p_rdata;
                    state_next = ST_WALK_GP;
                end
            end

            ST_WALK_GP:
            begin
                // halve the path: link to the grandparent and move there
                wr.parent_we = 1'b1;
                p_waddr      = x_reg;
                p_wdata      = p_rdata;
                p_raddr      = p_rdata;
                x_next       = p_rdata;
                steps_next   = CW'(steps_reg + 1'b1);
                state_next   = ST_WALK_P;
            end

            ST_SRC_A:
            begin
                sa_next    = s_rdata;
                s_raddr    = x_reg;
                state_next = ST_SRC_B;
            end

            ST_SRC_B:
            begin
                if ((sa_reg & s_rdata) != '0)
                begin
                    res_root_next = ra_reg;
                    res_ok_next   = 1'b0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    wr.parent_we  = 1'b1;
                    wr.sources_we = 1'b1;
                    p_waddr       = hi_idx;
                    p_wdata       = lo_idx;
                    s_waddr       = lo_idx;
                    s_wdata       = sa_reg | s_rdata;
                    hi_next       = hi_idx;
                    res_root_next = lo_idx;
                    res_ok_next   = 1'b1;
                    state_next    = ST_CLEAR;
                end
            end

            ST_CLEAR:
            begin
                wr.sources_we = 1'b1;
                s_waddr       = hi_reg;
                s_wdata       = '0;
                state_next    = ST_FINISH;
            end

            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    root_next      = scuf_pkg::MemberW'(res_root_reg);
                    accepted_next  = res_ok_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= scuf_pkg::CMD_LOAD;
            x_reg         <= '0;
            steps_reg     <= '0;
            second_reg    <= 1'b0;
            ra_reg        <= '0;
            hi_reg        <= '0;
            sa_reg        <= '0;
            res_root_reg  <= '0;
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
            accepted_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            x_reg         <= x_next;
            steps_reg     <= steps_next;
            second_reg    <= second_next;
            ra_reg        <= ra_next;
            hi_reg        <= hi_next;
            sa_reg        <= sa_next;
            res_root_reg  <= res_root_next;
            res_ok_reg    <= res_ok_next;
            out_valid_reg <= out_valid_next;
            root_reg      <= root_next;
            accepted_reg  <= accepted_next;
        end
    end

endmodule

/* rtl/core/source_constrained_union_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_constrained_union_find
// Disjoint-set table with per-group source masks: load, find with path
// halving, and a join that is refused when the two groups share a source.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid / in_stall   | cmd, first_member, second_member,
//          |           |                       | source_index
//  out     | output    | out_valid / out_stall | root, accepted
//
//  One transaction is worked at a time. Every command first passes the member
//  reduction; a find then walks from its member to the root, and a join walks
//  from both members in turn. A join whose roots match ends there; otherwise
//  the source masks decide a refusal or a merge. Each walk step reads the parent
//  and then the grandparent on the single read port of the parent table.
//  Reset clears only control state; both tables hold garbage until written.
//  A stalled output holds its transaction while the block takes the next
//  input; a further result then waits until the output register is free.
//
module source_constrained_union_find #(
    parameter int MAX_MEMBERS = scuf_pkg::MaxMembersDefault,
    parameter int NUM_SOURCES = scuf_pkg::NumSourcesDefault
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [scuf_pkg::CmdW-1:0]         cmd,
    input  logic [scuf_pkg::MemberW-1:0]      first_member,
    input  logic [scuf_pkg::MemberW-1:0]      second_member,
    input  logic [scuf_pkg::SourceIdxW-1:0]   source_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [scuf_pkg::MemberW-1:0]      root,
    output logic                              accepted
);

    localparam int MW = $clog2(MAX_MEMBERS);
    localparam int SW = $clog2(NUM_SOURCES);

    logic                   load;
    logic [MW-1:0]          first_idx;
    logic [MW-1:0]          second_idx;
    logic [SW-1:0]          source_idx;
    scuf_pkg::mem_wr_t      wr;
    logic [MW-1:0]          p_waddr;
    logic [MW-1:0]          p_wdata;
    logic [MW-1:0]          p_raddr;
    logic [MW-1:0]          p_rdata;
    logic [MW-1:0]          s_waddr;
    logic [NUM_SOURCES-1:0] s_wdata;
    logic [MW-1:0]          s_raddr;
    logic [NUM_SOURCES-1:0] s_rdata;

    scuf_reduce #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .NUM_SOURCES (NUM_SOURCES)
    ) u_reduce (
        .clk        (clk),
        .load       (load),
        .first_raw  (first_member),
        .second_raw (second_member),
        .source_raw (source_index),
        .first_idx  (first_idx),
        .second_idx (second_idx),
        .source_idx (source_idx)
    );

    scuf_mem #(
        .DEPTH (MAX_MEMBERS),
        .WIDTH (MW)
    ) u_parent_mem (
        .clk   (clk),
        .we    (wr.parent_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    scuf_mem #(
        .DEPTH (MAX_MEMBERS),
        .WIDTH (NUM_SOURCES)
    ) u_sources_mem (
        .clk   (clk),
        .we    (wr.sources_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    scuf_ctrl #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .NUM_SOURCES (NUM_SOURCES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .root       (root),
        .accepted   (accepted),
        .load       (load),
        .first_idx  (first_idx),
        .second_idx (second_idx),
        .source_idx (source_idx),
        .wr         (wr),
        .p_waddr    (p_waddr),
        .p_wdata    (p_wdata),
        .p_raddr    (p_raddr),
        .p_rdata    (p_rdata),
        .s_waddr    (s_waddr),
        .s_wdata    (s_wdata),
        .s_raddr    (s_raddr),
        .s_rdata    (s_rdata)
    );

`ifndef NO_ASSERTIONS
    // an accepted transaction makes the block busy at once
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again before the transaction was worked");

    // no table write while the block is idle
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(wr.parent_we || wr.sources_we))
        else $error("table written while idle");

    // links written during a load or merge stay inside the table
    a_link_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.sources_we && wr.parent_we) |->
            ((MW + 1)'(p_wdata) < (MW + 1)'(MAX_MEMBERS)) &&
            ((MW + 1)'(p_waddr) < (MW + 1)'(MAX_MEMBERS)))
        else $error("parent link written out of range");
`endif

endmodule
